[rtl/rfd_pkg.sv]
// Shared types and constants for the radar fall detector.
// Used by rfd_serdiv, radar_fall_detector, rfd_fall_checker and the testbench top; depends on nothing.
`default_nettype none

package rfd_pkg;

    // Field and register widths
    localparam int MOTION_W  = 16;
    localparam int DIST_W    = 16;
    localparam int TIME_W    = 32;
    localparam int THR_W     = 16;
    localparam int SETTLE_W  = 20;
    localparam int CONF_W    = 10;
    localparam int STATE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    // Serial divider geometry
    localparam int DIV_W     = 32;
    localparam int DIVISOR_W = THR_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DSTEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [THR_W-1:0]    RST_IMPACT  = 16'd2048;
    localparam logic [THR_W-1:0]    RST_STILL   = 16'd512;
    localparam logic [THR_W-1:0]    RST_RECOVER = 16'd1024;
    localparam logic [THR_W-1:0]    RST_DSTEP   = 16'd300;
    localparam logic [SETTLE_W-1:0] RST_SETTLE  = 20'd10000;

    // Fall phases, also the reported fall_state codes
    localparam logic [STATE_W-1:0] PH_NORMAL    = 2'd0;
    localparam logic [STATE_W-1:0] PH_SUSPECTED = 2'd1;
    localparam logic [STATE_W-1:0] PH_CONFIRMED = 2'd2;

    // Confidence limits in thousandths
    localparam logic [CONF_W-1:0] CONF_SUS_MIN  = 10'd400;
    localparam logic [CONF_W-1:0] CONF_SUS_MAX  = 10'd600;
    localparam logic [CONF_W-1:0] CONF_BUMP     = 10'd100;
    localparam logic [CONF_W-1:0] CONF_CONF_MIN = 10'd700;
    localparam logic [CONF_W-1:0] CONF_CONF_MAX = 10'd950;
    localparam logic [CONF_W-1:0] CONF_BASE     = 10'd600;

    // Elapsed-time quotient bounds where the confirmed clamp takes effect
    localparam logic [DIV_W-1:0] TERM_LOW  = 32'd100;
    localparam logic [DIV_W-1:0] TERM_HIGH = 32'd350;

    localparam logic [DIVISOR_W-1:0] MS_PER_TERM = 17'd20;
    localparam logic [9:0]           MILLI       = 10'd1000;

endpackage

`default_nettype wire

[rtl/rfd_serdiv.sv]
// Bit-serial restoring divider: one quotient bit per clock while busy.
// Depends on rfd_pkg for widths.
`default_nettype none

module rfd_serdiv
    import rfd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DIV_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      done,
    output logic [DIV_W-1:0]          quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    // Bring the next dividend bit down into the partial remainder
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            if (fits) begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/radar_fall_detector.sv]
// Radar fall detector: one input word per radar frame, zero or one event word out.
// The earliest next frame is taken after the capture and decide steps for a frame
// that raises no event, and after capture, decide and emit for a plain clear.
// A frame that raises a suspected or confirmed fall runs the serial divider (one
// quotient bit per cycle, then a completion flag and the confidence pick) before
// emit; a suspected fall under a zero impact threshold goes straight to emit.
// A finished event waits in the output register, so the next frame is taken
// while it is still pending; a further event is held in the emit state, and
// the input stalls, until the pending word has left. Configuration takes effect
// at once; the user must write it only while no frame is in flight: the block does not enforce it.
// Depends on rfd_pkg and rfd_serdiv.
`default_nettype none

module radar_fall_detector
    import rfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,
    // frame input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [0] present, [16:1] motion_score, [32:17] distance_mm, [64:33] now_ms,
    // [65] ack, [71:66] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // event output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [1:0] fall_state, [11:2] confidence_milli, [27:12] event_distance_mm,
    // [31:28] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    // configuration
    logic [THR_W-1:0]    impact_reg, still_reg, recover_reg, dstep_reg;
    logic [SETTLE_W-1:0] settle_reg;

    // control state
    logic [1:0]         state_reg, state_next;
    logic [STATE_W-1:0] phase_reg, phase_next;
    logic [TIME_W-1:0]  start_ms_reg, start_ms_next;
    logic [DIST_W-1:0]  last_dist_reg, last_dist_next;
    logic               have_last_reg, have_last_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // captured frame
    logic                present_reg;
    logic [MOTION_W-1:0] motion_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                ack_reg;

    // pending event
    logic [STATE_W-1:0]    res_state_reg, res_state_next;
    logic [CONF_W-1:0]     res_conf_reg, res_conf_next;
    logic [DIST_W-1:0]     res_dist_reg, res_dist_next;
    logic                  bump_reg, bump_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // divider
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;

    logic              in_fire;
    logic              out_free;
    logic [DIST_W-1:0] dist_diff;
    logic [DIST_W-1:0] step;
    logic [TIME_W-1:0] elapsed;
    logic [25:0]       motion_milli;
    logic [CONF_W-1:0] sus_conf, sus_bumped, conf_conf;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = state_reg == ST_IDLE;

    assign dist_diff = (dist_reg >= last_dist_reg) ? DIST_W'(dist_reg - last_dist_reg)
                                                    : DIST_W'(last_dist_reg - dist_reg);
    assign step      = (have_last_reg && present_reg) ? dist_diff : '0;
    assign elapsed   = now_reg - start_ms_reg;
    assign motion_milli = 26'(motion_reg) * 26'(MILLI);

    // clamp the impact ratio, then add the distance bonus and clamp again; also clamp the confirmed confidence
    always_comb begin
        if (div_quo < DIV_W'(CONF_SUS_MIN)) begin
            sus_conf = CONF_SUS_MIN;
        end else if (div_quo > DIV_W'(CONF_SUS_MAX)) begin
            sus_conf = CONF_SUS_MAX;
        end else begin
            sus_conf = div_quo[CONF_W-1:0];
        end
        sus_bumped = sus_conf + CONF_BUMP;
        if (sus_bumped > CONF_SUS_MAX) begin
            sus_bumped = CONF_SUS_MAX;
        end
        if (div_quo >= TERM_HIGH) begin
            conf_conf = CONF_CONF_MAX;
        end else if (div_quo < TERM_LOW) begin
            conf_conf = CONF_CONF_MIN;
        end else begin
            conf_conf = CONF_BASE + div_quo[CONF_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        start_ms_next  = start_ms_reg;
        last_dist_next = last_dist_reg;
        have_last_next = have_last_reg;
        res_state_next = res_state_reg;
        res_conf_next  = res_conf_reg;
        res_dist_next  = res_dist_reg;
        bump_next      = bump_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        div_start      = 1'b0;
        div_dividend   = {6'd0, motion_milli};
        div_divisor    = {impact_reg, 1'b0};

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (present_reg) begin
                    last_dist_next = dist_reg;
                    have_last_next = 1'b1;
                end
                res_state_next = PH_NORMAL;
                res_conf_next  = '0;
                res_dist_next  = dist_reg;
                state_next     = ST_IDLE;
                if (ack_reg && (phase_reg == PH_SUSPECTED || phase_reg == PH_CONFIRMED)) begin
                    phase_next = PH_NORMAL;
                    state_next = ST_EMIT;
                end else if (phase_reg == PH_SUSPECTED) begin
                    if (!present_reg) begin
                        phase_next    = PH_NORMAL;
                        res_dist_next = '0;
                        state_next    = ST_EMIT;
                    end else if (motion_reg > still_reg) begin
                        phase_next = PH_NORMAL;
                        state_next = ST_EMIT;
                    end else if (elapsed >= TIME_W'(settle_reg)) begin
                        phase_next     = PH_CONFIRMED;
                        res_state_next = PH_CONFIRMED;
                        div_start      = 1'b1;
                        div_dividend   = elapsed;
                        div_divisor    = MS_PER_TERM;
                        state_next     = ST_DIV;
                    end
                end else if (phase_reg == PH_CONFIRMED) begin
                    if (!present_reg || motion_reg >= recover_reg) begin
                        phase_next = PH_NORMAL;
                        state_next = ST_EMIT;
                    end
                end else begin
                    // normal phase, and the unused code handled as normal
                    phase_next = PH_NORMAL;
                    if (present_reg && motion_reg >= impact_reg) begin
                        phase_next     = PH_SUSPECTED;
                        start_ms_next  = now_reg;
                        res_state_next = PH_SUSPECTED;
                        bump_next      = step >= dstep_reg;
                        if (impact_reg == '0) begin
                            res_conf_next = CONF_SUS_MAX;
                            state_next    = ST_EMIT;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (res_state_reg == PH_CONFIRMED) begin
                        res_conf_next = conf_conf;
                    end else begin
                        res_conf_next = bump_reg ? sus_bumped : sus_conf;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, res_dist_reg, res_conf_reg, res_state_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            impact_reg    <= RST_IMPACT;
            still_reg     <= RST_STILL;
            recover_reg   <= RST_RECOVER;
            dstep_reg     <= RST_DSTEP;
            settle_reg    <= RST_SETTLE;
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_NORMAL;
            start_ms_reg  <= '0;
            last_dist_reg <= '0;
            have_last_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_IMPACT:  impact_reg  <= cfg_wdata[THR_W-1:0];
                    CFG_STILL:   still_reg   <= cfg_wdata[THR_W-1:0];
                    CFG_RECOVER: recover_reg <= cfg_wdata[THR_W-1:0];
                    CFG_DSTEP:   dstep_reg   <= cfg_wdata[THR_W-1:0];
                    CFG_SETTLE:  settle_reg  <= cfg_wdata[SETTLE_W-1:0];
                    default: begin
                    end
                endcase
            end
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            start_ms_reg  <= start_ms_next;
            last_dist_reg <= last_dist_next;
            have_last_reg <= have_last_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            present_reg <= s_tdata[0];
            motion_reg  <= s_tdata[16:1];
            dist_reg    <= s_tdata[32:17];
            now_reg     <= s_tdata[64:33];
            ack_reg     <= s_tdata[65];
        end
        res_state_reg <= res_state_next;
        res_conf_reg  <= res_conf_next;
        res_dist_reg  <= res_dist_next;
        bump_reg      <= bump_next;
        m_tdata_reg   <= m_tdata_next;
    end

    rfd_serdiv u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[verif/rfd_fall_checker.sv]
// Fall event checker: watches the frame, event and configuration ports of the
// radar fall detector, predicts every event word and compares it as it leaves.
// Depends on rfd_pkg for widths, register indexes and phase codes.
`timescale 1ns / 1ps

module rfd_fall_checker
    import rfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    output int unsigned                outstanding,
    output int unsigned                fault_count
);

    // Same bit order as the event word: fall_state in the lowest bits
    typedef struct packed {
        logic [DIST_W-1:0]  dist_mm;
        logic [CONF_W-1:0]  conf;
        logic [STATE_W-1:0] state;
    } fall_report_t;

    fall_report_t reports_q[$];
    int unsigned  faults = 0;

    logic [THR_W-1:0]    impact_thr;
    logic [THR_W-1:0]    still_thr;
    logic [THR_W-1:0]    recover_thr;
    logic [THR_W-1:0]    dstep_thr;
    logic [SETTLE_W-1:0] settle_win;

    logic [STATE_W-1:0] track_phase;
    logic [TIME_W-1:0]  suspect_t0;
    logic [DIST_W-1:0]  prev_dist;
    logic               prev_dist_ok;

    task automatic flag_fault(input string msg);
        faults++;
        if (faults <= 10) $display("%0t: %s", $time, msg);
    endtask

    task automatic push_report(input logic [STATE_W-1:0] st, input logic [CONF_W-1:0] conf,
                               input logic [DIST_W-1:0] dist_mm);
        fall_report_t r;
        r.state   = st;
        r.conf    = conf;
        r.dist_mm = dist_mm;
        reports_q.push_back(r);
    endtask

    // Advance the fall phase by one frame word and queue the event it raises
    task automatic track_frame(input logic [IN_DATA_W-1:0] w);
        logic                present;
        logic                ack;
        logic [MOTION_W-1:0] motion;
        logic [DIST_W-1:0]   dist_mm;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   elapsed;
        logic [31:0]         ratio;
        logic [31:0]         term;
        logic [31:0]         total;
        logic [DIST_W-1:0]   step;
        logic [CONF_W-1:0]   conf;
        present = w[0];
        motion  = w[16:1];
        dist_mm = w[32:17];
        now     = w[64:33];
        ack     = w[65];

        step = '0;
        if (prev_dist_ok && present)
            step = (dist_mm >= prev_dist) ? dist_mm - prev_dist : prev_dist - dist_mm;
        if (present) begin
            prev_dist    = dist_mm;
            prev_dist_ok = 1'b1;
        end

        if (ack && track_phase != PH_NORMAL) begin
            track_phase = PH_NORMAL;
            push_report(PH_NORMAL, '0, dist_mm);
        end else if (track_phase == PH_NORMAL) begin
            if (present && motion >= impact_thr) begin
                if (impact_thr == '0) begin
                    conf = CONF_SUS_MAX;
                end else begin
                    ratio = (32'(motion) * 32'(MILLI)) / (32'(impact_thr) << 1);
                    conf  = (ratio < CONF_SUS_MIN) ? CONF_SUS_MIN :
                            (ratio > CONF_SUS_MAX) ? CONF_SUS_MAX : ratio[CONF_W-1:0];
                end
                // a distance jump corroborates the impact
                if (step >= dstep_thr)
                    conf = (conf + CONF_BUMP > CONF_SUS_MAX) ? CONF_SUS_MAX : conf + CONF_BUMP;
                track_phase = PH_SUSPECTED;
                suspect_t0  = now;
                push_report(PH_SUSPECTED, conf, dist_mm);
            end
        end else if (track_phase == PH_SUSPECTED) begin
            elapsed = now - suspect_t0;
            if (!present) begin
                track_phase = PH_NORMAL;
                push_report(PH_NORMAL, '0, '0);
            end else if (motion > still_thr) begin
                track_phase = PH_NORMAL;
                push_report(PH_NORMAL, '0, dist_mm);
            end else if (elapsed >= 32'(settle_win)) begin
                term = elapsed / 32'd20;
                if (term > 32'd950) term = 32'd950;
                total = 32'(CONF_BASE) + term;
                conf  = (total < CONF_CONF_MIN) ? CONF_CONF_MIN :
                        (total > CONF_CONF_MAX) ? CONF_CONF_MAX : total[CONF_W-1:0];
                track_phase = PH_CONFIRMED;
                push_report(PH_CONFIRMED, conf, dist_mm);
            end
        end else if (!present || motion >= recover_thr) begin
            track_phase = PH_NORMAL;
            push_report(PH_NORMAL, '0, dist_mm);
        end
    endtask

    always @(posedge aclk) begin
        fall_report_t got;
        fall_report_t want;
        if (!aresetn) begin
            impact_thr   = RST_IMPACT;
            still_thr    = RST_STILL;
            recover_thr  = RST_RECOVER;
            dstep_thr    = RST_DSTEP;
            settle_win   = RST_SETTLE;
            track_phase  = PH_NORMAL;
            suspect_t0   = '0;
            prev_dist    = '0;
            prev_dist_ok = 1'b0;
            reports_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_IMPACT:  impact_thr  = cfg_wdata[THR_W-1:0];
                    CFG_STILL:   still_thr   = cfg_wdata[THR_W-1:0];
                    CFG_RECOVER: recover_thr = cfg_wdata[THR_W-1:0];
                    CFG_DSTEP:   dstep_thr   = cfg_wdata[THR_W-1:0];
                    CFG_SETTLE:  settle_win  = cfg_wdata[SETTLE_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = fall_report_t'(m_tdata[DIST_W+CONF_W+STATE_W-1:0]);
                if (reports_q.size() == 0) begin
                    flag_fault($sformatf("unexpected event: state %0d conf %0d dist %0d",
                                         got.state, got.conf, got.dist_mm));
                end else begin
                    want = reports_q.pop_front();
                    if (got.state !== want.state || got.conf !== want.conf ||
                        got.dist_mm !== want.dist_mm)
                        flag_fault($sformatf({"event mismatch: expected state %0d conf %0d ",
                                              "dist %0d, got state %0d conf %0d dist %0d"},
                                             want.state, want.conf, want.dist_mm,
                                             got.state, got.conf, got.dist_mm));
                end
            end
            if (s_tvalid && s_tready) track_frame(s_tdata);
        end
        outstanding <= reports_q.size();
        fault_count <= faults;
    end

endmodule

[verif/tb_radar_fall_detector.sv]
// Top of the radar fall detector testbench: clock, reset, configuration writes
// and frame stimulus with random idling on both channels, and the verdict.
// Depends on rfd_pkg, radar_fall_detector and rfd_fall_checker.
`timescale 1ns / 1ps

module tb_radar_fall_detector;
    import rfd_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DAT_W-1:0]  cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [OUT_DATA_W-1:0] m_tdata;

    int unsigned outstanding;
    int unsigned fault_count;

    // Stimulus shaping only: a copy of the thresholds and the scene
    logic [THR_W-1:0]    impact_thr  = RST_IMPACT;
    logic [THR_W-1:0]    still_thr   = RST_STILL;
    logic [THR_W-1:0]    recover_thr = RST_RECOVER;
    logic [THR_W-1:0]    dstep_thr   = RST_DSTEP;
    logic [SETTLE_W-1:0] settle_win  = RST_SETTLE;
    logic [TIME_W-1:0]   clock_ms    = '0;
    logic [DIST_W-1:0]   pos_mm      = 16'd2500;
    int unsigned         frames_sent = 0;
    bit                  calm        = 1'b0;

    radar_fall_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rfd_fall_checker fall_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .fault_count (fault_count)
    );

    always #2 aclk = ~aclk;

    // Receiver: stall at random unless in the calm stretch
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 15);
    end

    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [THR_W-1:0] motion_upto(input logic [THR_W-1:0] thr);
        return 16'($urandom_range(thr, 0));
    endfunction

    function automatic logic [THR_W-1:0] motion_below(input logic [THR_W-1:0] thr);
        return (thr == '0) ? '0 : 16'($urandom_range(thr - 1, 0));
    endfunction

    function automatic logic [THR_W-1:0] motion_above(input logic [THR_W-1:0] thr);
        return (thr == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(16'hFFFF, thr + 1));
    endfunction

    function automatic logic [THR_W-1:0] motion_from(input logic [THR_W-1:0] thr);
        return 16'($urandom_range(16'hFFFF, thr));
    endfunction

    function automatic logic [DIST_W-1:0] drift();
        pos_mm = pos_mm + 16'($urandom_range(40)) - 16'd20;
        return pos_mm;
    endfunction

    function automatic logic [TIME_W-1:0] later(input int unsigned lo, input int unsigned hi);
        return clock_ms + $urandom_range(hi, lo);
    endfunction

    task automatic send_frame(input logic present, input logic [MOTION_W-1:0] motion,
                              input logic [DIST_W-1:0] dist_mm, input logic [TIME_W-1:0] now,
                              input logic ack);
        while (!calm && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, ack, now, dist_mm, motion, present};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        clock_ms = now;
        frames_sent++;
    endtask

    // Hold the sender until every predicted event has left, then wait out the block
    task automatic drain_events(input int tail);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] impact, input logic [THR_W-1:0] still,
                                  input logic [THR_W-1:0] recover, input logic [THR_W-1:0] dstep,
                                  input logic [SETTLE_W-1:0] settle);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_IMPACT;
        cfg_wdata <= CFG_DAT_W'(impact);
        @(posedge aclk);
        cfg_addr  <= CFG_STILL;
        cfg_wdata <= CFG_DAT_W'(still);
        @(posedge aclk);
        cfg_addr  <= CFG_RECOVER;
        cfg_wdata <= CFG_DAT_W'(recover);
        @(posedge aclk);
        cfg_addr  <= CFG_DSTEP;
        cfg_wdata <= CFG_DAT_W'(dstep);
        @(posedge aclk);
        cfg_addr  <= CFG_SETTLE;
        cfg_wdata <= CFG_DAT_W'(settle);
        @(posedge aclk);
        cfg_we      <= 1'b0;
        impact_thr  = impact;
        still_thr   = still;
        recover_thr = recover;
        dstep_thr   = dstep;
        settle_win  = settle;
    endtask

    // One fall story: quiet frames, a spike, settling, then a clear or not
    task automatic fall_episode();
        int unsigned       k;
        logic [DIST_W-1:0] jump;
        repeat ($urandom_range(3))
            send_frame(1'b1, motion_upto(still_thr), drift(), later(50, 150),
                       1'($urandom_range(9) == 0));

        jump   = $urandom_range(1) ? dstep_thr + 16'($urandom_range(200))
                                   : 16'($urandom_range(dstep_thr));
        pos_mm = $urandom_range(1) ? pos_mm + jump : pos_mm - jump;
        send_frame(1'b1, motion_from(impact_thr), pos_mm, later(50, 150), 1'b0);

        k = $urandom_range(6, 1);
        repeat (k) begin
            case ($urandom_range(15))
                0: send_frame(1'b0, 16'($urandom), 16'($urandom), later(50, 150), 1'b0);
                1: send_frame(1'b1, motion_above(still_thr), drift(), later(50, 150), 1'b0);
                2: send_frame(1'($urandom), 16'($urandom), drift(), later(50, 150), 1'b1);
                default: send_frame(1'b1, motion_upto(still_thr), drift(),
                                    later(settle_win / k, settle_win / k + 300), 1'b0);
            endcase
        end

        repeat ($urandom_range(3))
            send_frame(1'b1, motion_below(recover_thr), drift(), later(0, 2000), 1'b0);
        case ($urandom_range(3))
            0: send_frame(1'b0, 16'($urandom), 16'($urandom), later(50, 150), 1'b0);
            1: send_frame(1'b1, motion_from(recover_thr), drift(), later(50, 150), 1'b0);
            2: send_frame(1'($urandom), 16'($urandom), drift(), later(50, 150), 1'b1);
            default: ;
        endcase
    endtask

    initial begin
        int unsigned target;
        int unsigned mid;
        bit          paused;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames on the reset thresholds
        send_frame(1'b0, 16'd0,     16'd0,     32'd0,         1'b0);
        send_frame(1'b1, 16'd0,     16'd0,     32'd100,       1'b1); // ack ignored in normal
        send_frame(1'b1, 16'hFFFF,  16'hFFFF,  32'hFFFF_FFF0, 1'b0); // spike with jump
        send_frame(1'b1, 16'd512,   16'hFFFF,  32'd9983,      1'b0); // one ms short, wrapped
        send_frame(1'b1, 16'd0,     16'hFFFF,  32'd9984,      1'b0); // confirm across wrap
        send_frame(1'b1, 16'd1023,  16'hFFFF,  32'd12000,     1'b0);
        send_frame(1'b1, 16'd1024,  16'd65000, 32'd12100,     1'b0); // recovers
        send_frame(1'b1, 16'd2048,  16'd64900, 32'd12200,     1'b0); // spike at threshold
        send_frame(1'b0, 16'd0,     16'd0,     32'd12300,     1'b0); // leaves while suspected
        send_frame(1'b1, 16'd2048,  16'd64000, 32'd12400,     1'b0); // threshold plus jump
        send_frame(1'b1, 16'd513,   16'd64000, 32'd12500,     1'b0); // moves while suspected
        send_frame(1'b1, 16'd3000,  16'd64000, 32'd12600,     1'b0);
        send_frame(1'b0, 16'd0,     16'd5,     32'd12700,     1'b1); // ack while suspected
        send_frame(1'b1, 16'd2048,  16'd64000, 32'd20000,     1'b0);
        send_frame(1'b1, 16'd0,     16'd64000, 32'd30000,     1'b0);
        send_frame(1'b0, 16'd0,     16'd123,   32'd30100,     1'b0); // leaves while confirmed
        send_frame(1'b1, 16'd2048,  16'd64000, 32'd40000,     1'b0);
        send_frame(1'b1, 16'd0,     16'd64000, 32'd50000,     1'b0);
        send_frame(1'b1, 16'd0,     16'd7,     32'd50100,     1'b1); // ack while confirmed
        send_frame(1'b1, 16'hFFFF,  16'd0,     32'd50200,     1'b1);
        send_frame(1'b1, 16'd512,   16'd0,     32'd50300,     1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            drain_events(40);
            case (ph)
                0: set_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 20'd0);
                1: set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'd600000);
                2: set_thresholds(16'd1, 16'd256, 16'd512, 16'd100, 20'd1500);
                3: set_thresholds(RST_IMPACT, RST_STILL, RST_RECOVER, RST_DSTEP, RST_SETTLE);
                4: set_thresholds(16'd4000, 16'd1000, 16'd3000, 16'd50, 20'd3000);
                5: set_thresholds(16'd768, 16'd300, 16'd600, 16'd1000, 20'd800);
                default: set_thresholds(16'($urandom), 16'($urandom), 16'($urandom),
                                        16'($urandom), 20'($urandom_range(600000)));
            endcase
            calm   = (ph == 3);
            target = frames_sent + 170;
            mid    = frames_sent + 85;
            paused = 1'b0;
            while (frames_sent < target) begin
                if (!paused && frames_sent >= mid) begin
                    drain_events(0);
                    paused = 1'b1;
                end
                if ($urandom_range(4) == 0)
                    send_frame(1'($urandom), 16'($urandom), 16'($urandom), $urandom,
                               1'($urandom));
                else
                    fall_episode();
            end
        end
        calm = 1'b0;

        drain_events(60);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[radar_fall_detector.f]
rtl/rfd_pkg.sv
rtl/rfd_serdiv.sv
rtl/radar_fall_detector.sv
verif/rfd_fall_checker.sv
verif/tb_radar_fall_detector.sv
